FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the core RTL; they compile away
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge, skipped while reset is high.
`define AOC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define AOC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define AOC_ASSERT(name, clk, rst, prop)
`define AOC_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

FILE: rtl/core/aoc_pkg.sv
// ----------------------------------------------------------------------------
// Ambiguous overlap counter package
// Shared widths, codes and state encoding of the overlap counter core.
// ----------------------------------------------------------------------------
package aoc_pkg;

   // default configuration
   localparam int DEF_MAX_INTERVALS = 1024;
   localparam int DEF_POS_WIDTH     = 32;

   // fixed field widths
   localparam int ENTRY_INDEX_WIDTH = 10;
   localparam int COUNT_WIDTH       = 11;
   localparam int RESULT_WIDTH      = 32;
   localparam int CSR_DATA_WIDTH    = 32;
   localparam int CSR_ADDR_WIDTH    = 3;

   // register index, taken from paddr bit 2
   localparam logic [0:0] REG_INTERVAL_COUNT = 1'b0;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QEND,
      ST_PROBE,
      ST_IEND,
      ST_CMP_END,
      ST_CMP_START,
      ST_CMP_POS,
      ST_CMP_CLIP,
      ST_COUNT,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/aoc_alu.sv
// ----------------------------------------------------------------------------
// Overlap counter add/subtract unit
// Shared adder of the search sequencer; the top result bit is the carry of
// an add or the borrow of a subtract.
// ----------------------------------------------------------------------------
module aoc_alu #(
   parameter int WIDTH = aoc_pkg::DEF_POS_WIDTH + 1
) (
   input  aoc_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]    op_a,
   input  logic [WIDTH-1:0]    op_b,
   output logic [WIDTH:0]      res
);

   // add or subtract one bit wider so the borrow lands in the top bit
   always_comb begin
      case (op)
         aoc_pkg::ALU_ADD: res = {1'b0, op_a} + {1'b0, op_b};
         aoc_pkg::ALU_SUB: res = {1'b0, op_a} - {1'b0, op_b};
         default:          res = '0;
      endcase
   end

endmodule

FILE: rtl/core/ambiguous_overlap_counter_top.sv
// ----------------------------------------------------------------------------
// Ambiguous overlap counter
// Sorted interval table with a binary-search overlap query.
// ----------------------------------------------------------------------------
// Usage:
// - Request beats (req_*) carry an opcode. A write beat stores interval_start
//   and interval_length at entry_index and gives no response; slots at or
//   above MAX_INTERVALS are dropped.
// - A query beat searches the first interval_count table entries (clamped to
//   MAX_INTERVALS) for the first probed interval overlapping the window
//   query_pos/query_len and returns one response beat with the number of
//   window bases that interval covers, or 0.
// - One shared adder forms the window end, the interval ends, the compares and
//   the count under a small sequencer. A query sets up its window end, then
//   each probe reads the table, forms the interval end and makes one or two
//   compares; an empty final probe ends the search, or a hit clips the overlap
//   and forms the count, and the response is then loaded.
// - req_stall is high while a query is in progress. A finished response waits
//   in the output register while rsp_stall is high; a new query may run, and
//   it holds its result until the register frees.
// - Reset clears interval_count and the sequencer; table contents stay
//   undefined until written. Configure only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ambiguous_overlap_counter_top #(
   parameter int MAX_INTERVALS = aoc_pkg::DEF_MAX_INTERVALS,
   parameter int POS_WIDTH     = aoc_pkg::DEF_POS_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic [aoc_pkg::ENTRY_INDEX_WIDTH-1:0]  req_entry_index,
   input  logic [POS_WIDTH-1:0]                   req_interval_start,
   input  logic [POS_WIDTH-1:0]                   req_interval_length,
   input  logic [POS_WIDTH-1:0]                   req_query_pos,
   input  logic [POS_WIDTH-1:0]                   req_query_len,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [aoc_pkg::RESULT_WIDTH-1:0]       rsp_ambiguous_bases,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [aoc_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [aoc_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [aoc_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   localparam int PW = POS_WIDTH;
   localparam int XW = POS_WIDTH + 1;
   localparam int AW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);

   // table: start in the upper half, length in the lower half
   logic [2*PW-1:0] table_mem [MAX_INTERVALS];
   logic [2*PW-1:0] rd_ff;
   logic            wr_en;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [PW-1:0]   off;
   logic [PW-1:0]   ilen;

   aoc_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  lo_ff, lo_in;
   logic [CW-1:0]  hi_ff, hi_in;
   logic [CW-1:0]  mid_ff, mid_in;
   logic [CW:0]    mid_sum;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [PW-1:0]  len_ff, len_in;
   logic [XW-1:0]  qend_ff, qend_in;
   logic [XW-1:0]  iend_ff, iend_in;
   logic           ge_ff, ge_in;
   logic           lt_ff, lt_in;
   logic [PW-1:0]  result_ff, result_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [aoc_pkg::RESULT_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic [aoc_pkg::COUNT_WIDTH-1:0]  count_ff;
   logic [CW-1:0]  hi_start;

   aoc_pkg::alu_op_type alu_op;
   logic [XW-1:0]  alu_a;
   logic [XW-1:0]  alu_b;
   logic [XW:0]    alu_res;
   logic           borrow;

   logic           req_beat;
   logic           out_free;
   logic           csr_wr;

   assign off  = rd_ff[2*PW-1:PW];
   assign ilen = rd_ff[PW-1:0];

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == aoc_pkg::REG_INTERVAL_COUNT);

   // hold the interval count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr) begin
         count_ff <= csr_pwdata[aoc_pkg::COUNT_WIDTH-1:0];
      end
   end

   // read back the interval count
   always_comb begin
      if (csr_paddr[2] == aoc_pkg::REG_INTERVAL_COUNT) begin
         csr_prdata = aoc_pkg::CSR_DATA_WIDTH'(count_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // clamp the searched range to the table size
   always_comb begin
      if (int'(count_ff) > MAX_INTERVALS) begin
         hi_start = CW'(MAX_INTERVALS);
      end else begin
         hi_start = CW'(count_ff);
      end
   end

   // ------------------------------------------------------------------
   // interval table
   // ------------------------------------------------------------------
   assign req_stall = (state_ff != aoc_pkg::ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign wr_en     = req_beat && (req_opcode == 1'(aoc_pkg::OP_WRITE)) &&
                      (int'(req_entry_index) < MAX_INTERVALS);

   // store one entry per write beat
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[AW'(req_entry_index)] <= {req_interval_start, req_interval_length};
      end
   end

   // read the probed entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= table_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------
   // shared adder
   // ------------------------------------------------------------------
   aoc_alu #(
      .WIDTH (XW)
   ) u_alu (
      .op   (alu_op),
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   assign borrow = alu_res[XW];

   // ------------------------------------------------------------------
   // search sequencer
   // ------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};

   // advance the search and steer the adder
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      qend_in      = qend_ff;
      iend_in      = iend_ff;
      ge_in        = ge_ff;
      lt_in        = lt_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = mid_sum[AW:1];
      alu_op       = aoc_pkg::ALU_ADD;
      alu_a        = {1'b0, pos_ff};
      alu_b        = {1'b0, len_ff};

      case (state_ff)
         aoc_pkg::ST_IDLE: begin
            if (req_beat && (req_opcode == 1'(aoc_pkg::OP_QUERY))) begin
               pos_in   = req_query_pos;
               len_in   = req_query_len;
               lo_in    = '0;
               hi_in    = hi_start;
               state_in = aoc_pkg::ST_QEND;
            end
         end
         aoc_pkg::ST_QEND: begin
            // window end
            qend_in  = alu_res[XW-1:0];
            state_in = aoc_pkg::ST_PROBE;
         end
         aoc_pkg::ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[CW:1];
               rd_en    = 1'b1;
               state_in = aoc_pkg::ST_IEND;
            end else begin
               result_in = '0;
               state_in  = aoc_pkg::ST_DONE;
            end
         end
         aoc_pkg::ST_IEND: begin
            // interval end
            alu_a    = {1'b0, off};
            alu_b    = {1'b0, ilen};
            iend_in  = alu_res[XW-1:0];
            state_in = aoc_pkg::ST_CMP_END;
         end
         aoc_pkg::ST_CMP_END: begin
            // window starts past the interval: search upper half
            alu_op = aoc_pkg::ALU_SUB;
            alu_a  = {1'b0, pos_ff};
            alu_b  = iend_ff;
            if (!borrow) begin
               lo_in    = mid_ff + CW'(1);
               state_in = aoc_pkg::ST_PROBE;
            end else begin
               state_in = aoc_pkg::ST_CMP_START;
            end
         end
         aoc_pkg::ST_CMP_START: begin
            // window ends before the interval: search lower half
            alu_op = aoc_pkg::ALU_SUB;
            alu_a  = {1'b0, off};
            alu_b  = qend_ff;
            if (!borrow) begin
               hi_in    = mid_ff;
               state_in = aoc_pkg::ST_PROBE;
            end else begin
               state_in = aoc_pkg::ST_CMP_POS;
            end
         end
         aoc_pkg::ST_CMP_POS: begin
            // window starts inside the interval
            alu_op   = aoc_pkg::ALU_SUB;
            alu_a    = {1'b0, pos_ff};
            alu_b    = {1'b0, off};
            ge_in    = !borrow;
            state_in = aoc_pkg::ST_CMP_CLIP;
         end
         aoc_pkg::ST_CMP_CLIP: begin
            // interval ends inside the window
            alu_op   = aoc_pkg::ALU_SUB;
            alu_a    = iend_ff;
            alu_b    = qend_ff;
            lt_in    = borrow;
            state_in = aoc_pkg::ST_COUNT;
         end
         aoc_pkg::ST_COUNT: begin
            // covered bases from the clipped overlap
            alu_op = aoc_pkg::ALU_SUB;
            if (ge_ff && lt_ff) begin
               alu_a = iend_ff;
               alu_b = {1'b0, pos_ff};
            end else if (ge_ff) begin
               alu_a = {1'b0, len_ff};
               alu_b = '0;
            end else if (lt_ff) begin
               alu_a = {1'b0, ilen};
               alu_b = '0;
            end else begin
               alu_a = qend_ff;
               alu_b = {1'b0, off};
            end
            result_in = alu_res[PW-1:0];
            state_in  = aoc_pkg::ST_DONE;
         end
         aoc_pkg::ST_DONE: begin
            // load the response once the output register frees
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = aoc_pkg::RESULT_WIDTH'(result_ff);
               state_in     = aoc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aoc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aoc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      qend_ff     <= qend_in;
      iend_ff     <= iend_in;
      ge_ff       <= ge_in;
      lt_ff       <= lt_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ambiguous_bases = rsp_data_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `AOC_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == aoc_pkg::ST_DONE))
   `AOC_ASSERT(a_search_bounds, clock, reset, (state_ff == aoc_pkg::ST_PROBE) |-> (lo_ff <= hi_ff) && (int'(hi_ff) <= MAX_INTERVALS))
   `AOC_ASSERT(a_count_within_window, clock, reset, (state_ff == aoc_pkg::ST_DONE) |-> (result_ff <= len_ff))

endmodule

FILE: test/ambiguous_overlap_counter_top_tb.sv
// ----------------------------------------------------------------------------
// Ambiguous overlap counter testbench
// Loads sorted interval tables through request beats and sets the searched
// entry count over the register port. Overlap queries are predicted by a
// software binary search, and response beats are checked against it in order.
// ----------------------------------------------------------------------------
module ambiguous_overlap_counter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH   = aoc_pkg::DEF_MAX_INTERVALS;
   localparam int TOTAL_ITEMS   = 1150;
   localparam int SETTLE_CYCLES = 64;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [aoc_pkg::CSR_ADDR_WIDTH-1:0] COUNT_ADDR =
      {aoc_pkg::REG_INTERVAL_COUNT, 2'b00};
   localparam logic [aoc_pkg::CSR_ADDR_WIDTH-1:0] SPARE_ADDR =
      {~aoc_pkg::REG_INTERVAL_COUNT, 2'b00};

   typedef struct {
      aoc_pkg::opcode_type                   op;
      logic [aoc_pkg::ENTRY_INDEX_WIDTH-1:0] slot;
      logic [31:0]                           istart;
      logic [31:0]                           ilen;
      logic [31:0]                           qpos;
      logic [31:0]                           qlen;
   } table_beat_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // Interval table mirror, searched entry count and queue of expected counts
   class overlap_tracker;
      logic [31:0]                      start_tab [TABLE_DEPTH];
      logic [31:0]                      len_tab [TABLE_DEPTH];
      logic [aoc_pkg::COUNT_WIDTH-1:0]  interval_count;
      logic [aoc_pkg::RESULT_WIDTH-1:0] pending_bases [$];
      int                               errors;

      function new();
         interval_count = '0;
         errors = 0;
      endfunction

      // Binary search for the first probed interval that overlaps the window
      function logic [aoc_pkg::RESULT_WIDTH-1:0] covered_bases(logic [31:0] pos,
                                                               logic [31:0] len);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         logic [32:0] wpos;
         logic [32:0] qend;
         logic [32:0] off;
         logic [32:0] iend;
         logic [32:0] span;
         lo = 0;
         hi = (interval_count > TABLE_DEPTH) ? TABLE_DEPTH : interval_count;
         wpos = {1'b0, pos};
         qend = wpos + {1'b0, len};
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            off = {1'b0, start_tab[mid]};
            iend = off + {1'b0, len_tab[mid]};
            if (wpos >= iend) begin
               lo = mid + 1;
            end else if (qend <= off) begin
               hi = mid;
            end else begin
               if (wpos >= off) begin
                  span = (iend < qend) ? iend - wpos : {1'b0, len};
               end else begin
                  span = (iend < qend) ? {1'b0, len_tab[mid]} : {1'b0, len} - (off - wpos);
               end
               return span[aoc_pkg::RESULT_WIDTH-1:0];
            end
         end
         return '0;
      endfunction

      // Store a table write, or queue the count a query will return
      function void note_beat(table_beat_type b);
         if (b.op == aoc_pkg::OP_WRITE) begin
            start_tab[b.slot] = b.istart;
            len_tab[b.slot] = b.ilen;
         end else begin
            pending_bases.push_back(covered_bases(b.qpos, b.qlen));
         end
      endfunction

      function void check_bases(logic [aoc_pkg::RESULT_WIDTH-1:0] got);
         logic [aoc_pkg::RESULT_WIDTH-1:0] want;
         if (pending_bases.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual %0d", $time, got);
            errors++;
         end else begin
            want = pending_bases.pop_front();
            if (got !== want) begin
               $display("%0t: ambiguous_bases mismatch, expected %0d, actual %0d",
                        $time, want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic                                   req_opcode = 1'b0;
   logic [aoc_pkg::ENTRY_INDEX_WIDTH-1:0]  req_entry_index = '0;
   logic [31:0]                            req_interval_start = '0;
   logic [31:0]                            req_interval_length = '0;
   logic [31:0]                            req_query_pos = '0;
   logic [31:0]                            req_query_len = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [aoc_pkg::RESULT_WIDTH-1:0]       rsp_ambiguous_bases;
   logic                                   csr_psel = 1'b0;
   logic                                   csr_penable = 1'b0;
   logic                                   csr_pwrite = 1'b0;
   logic [aoc_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr = '0;
   logic [aoc_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata = '0;
   logic [aoc_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata;
   logic                                   csr_pready;

   overlap_tracker sb;
   int unsigned    burst_left = 0;
   int unsigned    beats_sent = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    mode_left = 0;
   logic [31:0]    cycle_count = '0;

   ambiguous_overlap_counter_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_entry_index     (req_entry_index),
      .req_interval_start  (req_interval_start),
      .req_interval_length (req_interval_length),
      .req_query_pos       (req_query_pos),
      .req_query_len       (req_query_len),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ambiguous_bases (rsp_ambiguous_bases),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Check response beats and stall on a pattern that switches mode now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_bases(rsp_ambiguous_bases);
         cycle_count <= cycle_count + 1;
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 400);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (cycle_count[3:0] < 4'd10);
         endcase
      end
   end

   function automatic table_beat_type write_beat(int unsigned slot, logic [31:0] s,
                                                 logic [31:0] l);
      table_beat_type b;
      b.op = aoc_pkg::OP_WRITE;
      b.slot = aoc_pkg::ENTRY_INDEX_WIDTH'(slot);
      b.istart = s;
      b.ilen = l;
      b.qpos = $urandom;
      b.qlen = $urandom;
      return b;
   endfunction

   function automatic table_beat_type query_beat(logic [31:0] p, logic [31:0] l);
      table_beat_type b;
      b.op = aoc_pkg::OP_QUERY;
      b.slot = aoc_pkg::ENTRY_INDEX_WIDTH'($urandom);
      b.istart = $urandom;
      b.ilen = $urandom;
      b.qpos = p;
      b.qlen = l;
      return b;
   endfunction

   // Drive one request beat, opening a new burst after a random gap when due
   task automatic send_beat(table_beat_type b);
      int unsigned gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) gap = 0;
         else if ($urandom_range(0, 7) == 0) gap = $urandom_range(8, 40);
         else gap = $urandom_range(1, 4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_opcode <= b.op;
      req_entry_index <= b.slot;
      req_interval_start <= b.istart;
      req_interval_length <= b.ilen;
      req_query_pos <= b.qpos;
      req_query_len <= b.qlen;
      do @(posedge clock); while (req_stall);
      sb.note_beat(b);
      beats_sent++;
   endtask

   // Hold requests until every expected beat has arrived, then let the core settle
   task automatic drain(int unsigned extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_bases.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(logic [aoc_pkg::CSR_ADDR_WIDTH-1:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr[aoc_pkg::CSR_ADDR_WIDTH-1:2] == aoc_pkg::REG_INTERVAL_COUNT)
         sb.interval_count = data[aoc_pkg::COUNT_WIDTH-1:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_count();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= COUNT_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== aoc_pkg::CSR_DATA_WIDTH'(sb.interval_count)) begin
         $display("%0t: interval_count readback mismatch, expected %0d, actual %0d",
                  $time, sb.interval_count, csr_prdata);
         sb.errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write the count with random upper bits while idle, then read it back
   task automatic set_count(int unsigned value);
      logic [31:0] word;
      drain(SETTLE_CYCLES);
      word = $urandom;
      word[aoc_pkg::COUNT_WIDTH-1:0] = aoc_pkg::COUNT_WIDTH'(value);
      write_reg(COUNT_ADDR, word);
      read_count();
   endtask

   // Load slots 0..n-1 with intervals in ascending start order
   task automatic load_sorted(int unsigned n, int unsigned step_max);
      longint unsigned at;
      longint unsigned l;
      int unsigned     k;
      at = $urandom_range(0, step_max);
      for (k = 0; k < n; k++) begin
         l = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, step_max);
         if (k == n - 1 && $urandom_range(0, 3) == 0) l = ALL_ONES;
         if (at > ALL_ONES) at = ALL_ONES;
         send_beat(write_beat(k, 32'(at), 32'(l)));
         at += l + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, step_max));
      end
   endtask

   // Aim a window at or near a loaded interval, or send a free window
   task automatic send_query(int unsigned n);
      longint      s;
      longint      l;
      longint      p;
      longint      w;
      longint      r;
      int unsigned k;
      if (n == 0 || $urandom_range(0, 4) == 0) begin
         send_beat(query_beat($urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64)));
      end else begin
         k = $urandom_range(0, n - 1);
         s = sb.start_tab[k];
         l = sb.len_tab[k];
         r = $urandom;
         case ($urandom_range(0, 3))
            0: p = s - $urandom_range(0, 8);
            1: p = s + r % (l + 1);
            2: p = s + l - $urandom_range(0, 3);
            default: p = s + l + $urandom_range(0, 3);
         endcase
         if (p < 0) p = 0;
         if (p > ALL_ONES) p = ALL_ONES;
         r = $urandom;
         case ($urandom_range(0, 4))
            0: w = 0;
            1: w = $urandom_range(1, 8);
            2: w = r % (l + 16);
            3: w = ALL_ONES;
            default: w = r;
         endcase
         send_beat(query_beat(32'(p), 32'(w)));
      end
   endtask

   // Set a count, sometimes reload a small sorted table, then mix queries and noise writes
   task automatic run_phase(int unsigned count_value, int unsigned items);
      int unsigned n;
      int unsigned step_max;
      n = (count_value > TABLE_DEPTH) ? TABLE_DEPTH : count_value;
      set_count(count_value);
      if (n > 0 && n <= 48 && $urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 2))
            0: step_max = 16;
            1: step_max = 4096;
            default: step_max = ALL_ONES / (2 * (n + 1));
         endcase
         load_sorted(n, step_max);
      end
      repeat (items) begin
         if ($urandom_range(0, 9) == 0)
            send_beat(write_beat($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom));
         else
            send_query(n);
      end
   endtask

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int unsigned cv;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_count();

      // Empty search with zero count, then a small table with a wide last entry
      send_beat(query_beat(ALL_ONES, ALL_ONES));
      send_beat(write_beat(0, 100, 50));
      send_beat(write_beat(1, 200, 0));
      send_beat(write_beat(2, 300, 100));
      send_beat(write_beat(3, 32'hFFFF_FF00, ALL_ONES));
      send_beat(write_beat(TABLE_DEPTH - 1, ALL_ONES, ALL_ONES));

      // A write past the register list must leave the count alone
      drain(SETTLE_CYCLES);
      write_reg(SPARE_ADDR, $urandom);
      read_count();
      set_count(4);

      // Window inside, covering, overlapping either end, empty interval, empty window
      send_beat(query_beat(110, 10));
      send_beat(query_beat(90, 100));
      send_beat(query_beat(80, 30));
      send_beat(query_beat(140, 30));
      send_beat(query_beat(200, 10));
      send_beat(query_beat(120, 0));
      send_beat(query_beat(0, ALL_ONES));
      send_beat(query_beat(ALL_ONES, ALL_ONES));
      send_beat(query_beat(32'hFFFF_FF80, 16));
      // Break the start order and search anyway
      send_beat(write_beat(1, 500, 20));
      send_beat(query_beat(505, 3));

      // Fill the whole table, then search it at full size and past it
      load_sorted(TABLE_DEPTH, ALL_ONES / (2 * (TABLE_DEPTH + 1)));
      run_phase(TABLE_DEPTH, 24);
      run_phase((1 << aoc_pkg::COUNT_WIDTH) - 1, 16);
      run_phase(TABLE_DEPTH + 1, 8);

      while (beats_sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 9))
            0: cv = $urandom_range(TABLE_DEPTH - 1, (1 << aoc_pkg::COUNT_WIDTH) - 1);
            1: cv = $urandom_range(0, TABLE_DEPTH);
            default: cv = $urandom_range(0, 40);
         endcase
         run_phase(cv, $urandom_range(10, 30));
      end

      drain(SETTLE_CYCLES);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
